### src/point_segment_nearest_core_defines.svh
// assertion macros for the point to segment nearest point core
// no dependencies; the including module supplies clock and reset
`ifndef POINT_SEGMENT_NEAREST_CORE_DEFINES_SVH
`define POINT_SEGMENT_NEAREST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSN_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("psn assertion failed");
`define PSN_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("psn assertion failed");
`else
`define PSN_ASSERT(lbl, prop)
`define PSN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/psn_pkg.sv
// types and widths for the point to segment nearest point core
// no dependencies
package psn_pkg;

   localparam int CW  = 24;           // coordinate width
   localparam int VW  = CW + 1;       // difference width
   localparam int PW  = 2 * VW;       // signed product width
   localparam int C1W = PW + 1;       // projection width
   localparam int C2W = 2 * CW + 1;   // squared length width
   localparam int LW  = CW + 1;       // low split of projection
   localparam int HW  = CW;           // high split of projection
   localparam int NW  = 3 * CW + 1;   // numerator width
   localparam int SQW = 2 * CW + 1;   // squared distance width
   localparam int RW  = CW + 1;       // root width
   localparam int TW  = SQW + 2;      // root trial width

   typedef enum logic [1:0] {
      REGION_START = 2'd0,
      REGION_END   = 2'd1,
      REGION_FOOT  = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [RW-1:0]        distance;
      logic signed [CW-1:0] nearest_x;
      logic signed [CW-1:0] nearest_y;
      region_type           region;
   } rsp_type;

endpackage

### src/point_segment_nearest_core.sv
// one transfer per cycle while rsp_ready is high
// the pipeline includes the 24 stage divider and the 25 stage square root pipelines
// the whole pipeline holds only while a response waits with rsp_ready low
// synchronous active high reset clears all stage valid bits; payload is not reset
// depends on psn_pkg and point_segment_nearest_core_defines.svh
`include "point_segment_nearest_core_defines.svh"
module point_segment_nearest_core import psn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic adv;

   // stage 1: differences
   logic s1_vld_ff;
   req_type s1_req_ff;
   logic signed [VW-1:0] s1_vx_ff, s1_vy_ff, s1_wx_ff, s1_wy_ff;

   // stage 2: products
   logic s2_vld_ff;
   req_type s2_req_ff;
   logic signed [PW-1:0] s2_pxx_ff, s2_pyy_ff, s2_vxx_ff, s2_vyy_ff;
   logic [CW-1:0] s2_avx_ff, s2_avy_ff;
   logic s2_negx_ff, s2_negy_ff;

   // stage 3: projection, squared length, region
   logic signed [C1W-1:0] s3_c1_in;
   logic [C2W-1:0] s3_c2_in;
   region_type s3_reg_in;
   logic s3_vld_ff;
   req_type s3_req_ff;
   region_type s3_reg_ff;
   logic [C2W-1:0] s3_c1_ff, s3_c2_ff;
   logic [CW-1:0] s3_avx_ff, s3_avy_ff;
   logic s3_negx_ff, s3_negy_ff;

   // stage 4: split partial products
   logic s4_vld_ff;
   req_type s4_req_ff;
   region_type s4_reg_ff;
   logic [C2W-1:0] s4_c2_ff;
   logic [LW+CW-1:0] s4_plx_ff, s4_ply_ff;
   logic [HW+CW-1:0] s4_phx_ff, s4_phy_ff;
   logic [CW-1:0] s4_avx_ff, s4_avy_ff;
   logic s4_negx_ff, s4_negy_ff;

   // divider pipeline
   logic dv_vld_ff [0:CW];
   req_type dv_req_ff [0:CW];
   region_type dv_reg_ff [0:CW];
   logic [C2W-1:0] dv_c2_ff [0:CW];
   logic [NW-1:0] dv_rx_ff [0:CW];
   logic [NW-1:0] dv_ry_ff [0:CW];
   logic [CW-1:0] dv_qx_ff [0:CW];
   logic [CW-1:0] dv_qy_ff [0:CW];
   logic [CW-1:0] dv_avx_ff [0:CW];
   logic [CW-1:0] dv_avy_ff [0:CW];
   logic dv_negx_ff [0:CW];
   logic dv_negy_ff [0:CW];

   // stage 6: rounding and nearest point
   logic [CW-1:0] s6_qx_in, s6_qy_in;
   logic signed [VW-1:0] s6_offx_in, s6_offy_in;
   logic signed [CW-1:0] s6_nx_in, s6_ny_in;
   logic s6_vld_ff;
   req_type s6_req_ff;
   region_type s6_reg_ff;
   logic signed [CW-1:0] s6_nx_ff, s6_ny_ff;

   // stage 7: offsets to nearest point
   logic s7_vld_ff;
   region_type s7_reg_ff;
   logic signed [CW-1:0] s7_nx_ff, s7_ny_ff;
   logic signed [VW-1:0] s7_dx_ff, s7_dy_ff;

   // stage 8: squares
   logic s8_vld_ff;
   region_type s8_reg_ff;
   logic signed [CW-1:0] s8_nx_ff, s8_ny_ff;
   logic signed [PW-1:0] s8_dxx_ff, s8_dyy_ff;

   // square root pipeline
   logic sq_vld_ff [0:RW];
   region_type sq_reg_ff [0:RW];
   logic signed [CW-1:0] sq_nx_ff [0:RW];
   logic signed [CW-1:0] sq_ny_ff [0:RW];
   logic [SQW-1:0] sq_r_ff [0:RW];
   logic [RW-1:0] sq_root_ff [0:RW];

   assign adv       = !sq_vld_ff[RW] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = sq_vld_ff[RW];
   always_comb begin
      rsp_data.distance  = sq_root_ff[RW];
      rsp_data.nearest_x = sq_nx_ff[RW];
      rsp_data.nearest_y = sq_ny_ff[RW];
      rsp_data.region    = sq_reg_ff[RW];
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff <= req_data;
         s1_vx_ff  <= VW'(req_data.end_x) - VW'(req_data.start_x);
         s1_vy_ff  <= VW'(req_data.end_y) - VW'(req_data.start_y);
         s1_wx_ff  <= VW'(req_data.point_x) - VW'(req_data.start_x);
         s1_wy_ff  <= VW'(req_data.point_y) - VW'(req_data.start_y);
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_req_ff  <= s1_req_ff;
         s2_pxx_ff  <= s1_wx_ff * s1_vx_ff;
         s2_pyy_ff  <= s1_wy_ff * s1_vy_ff;
         s2_vxx_ff  <= s1_vx_ff * s1_vx_ff;
         s2_vyy_ff  <= s1_vy_ff * s1_vy_ff;
         s2_negx_ff <= s1_vx_ff[VW-1];
         s2_negy_ff <= s1_vy_ff[VW-1];
         s2_avx_ff  <= s1_vx_ff[VW-1] ? CW'(-s1_vx_ff) : CW'(s1_vx_ff);
         s2_avy_ff  <= s1_vy_ff[VW-1] ? CW'(-s1_vy_ff) : CW'(s1_vy_ff);
      end
   end

   // stage 3
   always_comb begin
      s3_c1_in = C1W'(s2_pxx_ff) + C1W'(s2_pyy_ff);
      s3_c2_in = C2W'($unsigned(s2_vxx_ff)) + C2W'($unsigned(s2_vyy_ff));
      if (s3_c1_in[C1W-1] || s3_c1_in == '0) begin
         s3_reg_in = REGION_START;
      end else if (C1W'(s3_c2_in) <= $unsigned(s3_c1_in)) begin
         s3_reg_in = REGION_END;
      end else begin
         s3_reg_in = REGION_FOOT;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_req_ff  <= s2_req_ff;
         s3_reg_ff  <= s3_reg_in;
         s3_c1_ff   <= C2W'($unsigned(s3_c1_in));
         s3_c2_ff   <= s3_c2_in;
         s3_avx_ff  <= s2_avx_ff;
         s3_avy_ff  <= s2_avy_ff;
         s3_negx_ff <= s2_negx_ff;
         s3_negy_ff <= s2_negy_ff;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_req_ff  <= s3_req_ff;
         s4_reg_ff  <= s3_reg_ff;
         s4_c2_ff   <= s3_c2_ff;
         s4_plx_ff  <= (LW+CW)'(s3_c1_ff[LW-1:0]) * (LW+CW)'(s3_avx_ff);
         s4_ply_ff  <= (LW+CW)'(s3_c1_ff[LW-1:0]) * (LW+CW)'(s3_avy_ff);
         s4_phx_ff  <= (HW+CW)'(s3_c1_ff[C2W-1:LW]) * (HW+CW)'(s3_avx_ff);
         s4_phy_ff  <= (HW+CW)'(s3_c1_ff[C2W-1:LW]) * (HW+CW)'(s3_avy_ff);
         s4_avx_ff  <= s3_avx_ff;
         s4_avy_ff  <= s3_avy_ff;
         s4_negx_ff <= s3_negx_ff;
         s4_negy_ff <= s3_negy_ff;
      end
   end

   // divider entry: full numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= s4_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_req_ff[0]  <= s4_req_ff;
         dv_reg_ff[0]  <= s4_reg_ff;
         dv_c2_ff[0]   <= s4_c2_ff;
         dv_rx_ff[0]   <= NW'(s4_plx_ff) + (NW'(s4_phx_ff) << LW);
         dv_ry_ff[0]   <= NW'(s4_ply_ff) + (NW'(s4_phy_ff) << LW);
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
         dv_avx_ff[0]  <= s4_avx_ff;
         dv_avy_ff[0]  <= s4_avy_ff;
         dv_negx_ff[0] <= s4_negx_ff;
         dv_negy_ff[0] <= s4_negy_ff;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < CW; k++) begin : g_div
      localparam int B = CW - 1 - k;
      logic [NW-1:0] dshift;
      logic          takex, takey;
      assign dshift = NW'(dv_c2_ff[k]) << B;
      assign takex  = dv_rx_ff[k] >= dshift;
      assign takey  = dv_ry_ff[k] >= dshift;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_req_ff[k+1]  <= dv_req_ff[k];
            dv_reg_ff[k+1]  <= dv_reg_ff[k];
            dv_c2_ff[k+1]   <= dv_c2_ff[k];
            dv_rx_ff[k+1]   <= takex ? dv_rx_ff[k] - dshift : dv_rx_ff[k];
            dv_ry_ff[k+1]   <= takey ? dv_ry_ff[k] - dshift : dv_ry_ff[k];
            dv_qx_ff[k+1]   <= dv_qx_ff[k] | (CW'(takex) << B);
            dv_qy_ff[k+1]   <= dv_qy_ff[k] | (CW'(takey) << B);
            dv_avx_ff[k+1]  <= dv_avx_ff[k];
            dv_avy_ff[k+1]  <= dv_avy_ff[k];
            dv_negx_ff[k+1] <= dv_negx_ff[k];
            dv_negy_ff[k+1] <= dv_negy_ff[k];
         end
      end
   end

   // stage 6: round half up, apply sign, select by region
   always_comb begin
      s6_qx_in = dv_qx_ff[CW] + CW'((C2W+1)'(dv_rx_ff[CW][C2W-1:0]) << 1
                 >= (C2W+1)'(dv_c2_ff[CW]));
      s6_qy_in = dv_qy_ff[CW] + CW'((C2W+1)'(dv_ry_ff[CW][C2W-1:0]) << 1
                 >= (C2W+1)'(dv_c2_ff[CW]));
      s6_offx_in = dv_negx_ff[CW] ? -VW'({1'b0, s6_qx_in}) : VW'({1'b0, s6_qx_in});
      s6_offy_in = dv_negy_ff[CW] ? -VW'({1'b0, s6_qy_in}) : VW'({1'b0, s6_qy_in});
      case (dv_reg_ff[CW])
         REGION_START: begin
            s6_nx_in = dv_req_ff[CW].start_x;
            s6_ny_in = dv_req_ff[CW].start_y;
         end
         REGION_END: begin
            s6_nx_in = dv_req_ff[CW].end_x;
            s6_ny_in = dv_req_ff[CW].end_y;
         end
         default: begin
            s6_nx_in = CW'(VW'(dv_req_ff[CW].start_x) + s6_offx_in);
            s6_ny_in = CW'(VW'(dv_req_ff[CW].start_y) + s6_offy_in);
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= dv_vld_ff[CW];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_req_ff <= dv_req_ff[CW];
         s6_reg_ff <= dv_reg_ff[CW];
         s6_nx_ff  <= s6_nx_in;
         s6_ny_ff  <= s6_ny_in;
      end
   end

   // stage 7
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_reg_ff <= s6_reg_ff;
         s7_nx_ff  <= s6_nx_ff;
         s7_ny_ff  <= s6_ny_ff;
         s7_dx_ff  <= VW'(s6_req_ff.point_x) - VW'(s6_nx_ff);
         s7_dy_ff  <= VW'(s6_req_ff.point_y) - VW'(s6_ny_ff);
      end
   end

   // stage 8
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s8_reg_ff <= s7_reg_ff;
         s8_nx_ff  <= s7_nx_ff;
         s8_ny_ff  <= s7_ny_ff;
         s8_dxx_ff <= s7_dx_ff * s7_dx_ff;
         s8_dyy_ff <= s7_dy_ff * s7_dy_ff;
      end
   end

   // square root entry: squared distance
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s8_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_reg_ff[0]  <= s8_reg_ff;
         sq_nx_ff[0]   <= s8_nx_ff;
         sq_ny_ff[0]   <= s8_ny_ff;
         sq_r_ff[0]    <= SQW'($unsigned(s8_dxx_ff)) + SQW'($unsigned(s8_dyy_ff));
         sq_root_ff[0] <= '0;
      end
   end

   // one root bit per stage, remainder kept as n minus root squared
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int B = RW - 1 - k;
      logic [TW-1:0] trial;
      logic          take;
      assign trial = (TW'(sq_root_ff[k]) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = TW'(sq_r_ff[k]) >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_reg_ff[k+1]  <= sq_reg_ff[k];
            sq_nx_ff[k+1]   <= sq_nx_ff[k];
            sq_ny_ff[k+1]   <= sq_ny_ff[k];
            sq_r_ff[k+1]    <= take ? SQW'(TW'(sq_r_ff[k]) - trial) : sq_r_ff[k];
            sq_root_ff[k+1] <= sq_root_ff[k] | (RW'(take) << B);
         end
      end
   end

   `PSN_ASSERT(a_stall_holds_front, !req_ready |=> s1_vld_ff == $past(s1_vld_ff))
   `PSN_ASSERT(a_div_rem_x, dv_vld_ff[CW] && dv_reg_ff[CW] == REGION_FOOT |-> dv_rx_ff[CW] < NW'(dv_c2_ff[CW]))
   `PSN_ASSERT(a_div_quot_x, dv_vld_ff[CW] && dv_reg_ff[CW] == REGION_FOOT |-> dv_qx_ff[CW] < dv_avx_ff[CW] || dv_avx_ff[CW] == '0)
   `PSN_ASSERT(a_sqrt_floor, sq_vld_ff[RW] |-> (SQW+1)'(sq_r_ff[RW]) <= ((SQW+1)'(sq_root_ff[RW]) << 1))

endmodule

### sim/point_segment_nearest_checker.sv
// checker for the point to segment nearest point core: predicts each response
// from the request transfers it sees and compares it field by field
// depends on psn_pkg
module point_segment_nearest_checker import psn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      region_hits [3]
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_rsps [$];

   function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      logic [127:0] r;
      begin
         q = num / den;
         r = num % den;
         if (r >= den - r) q = q + 1;
         return q;
      end
   endfunction

   function automatic longint foot_offset(longint c1, longint v, longint c2);
      logic [127:0] mag;
      longint av;
      begin
         av = (v < 0) ? -v : v;
         mag = round_div(128'(c1) * 128'(av), 128'(c2));
         return (v < 0) ? -longint'(mag) : longint'(mag);
      end
   endfunction

   function automatic longint floor_sqrt(longint n);
      longint lo;
      longint hi;
      longint mid;
      begin
         lo = 0;
         hi = 64'd3037000499;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      end
   endfunction

   function automatic rsp_type nearest_on_segment(req_type q);
      longint px, py, sx, sy, ex, ey, vx, vy, wx, wy, c1, c2, nx, ny, dx, dy;
      rsp_type r;
      begin
         px = q.point_x; py = q.point_y;
         sx = q.start_x; sy = q.start_y;
         ex = q.end_x;   ey = q.end_y;
         vx = ex - sx; vy = ey - sy;
         wx = px - sx; wy = py - sy;
         c1 = wx * vx + wy * vy;
         c2 = vx * vx + vy * vy;
         if (c1 <= 0) begin
            nx = sx; ny = sy; r.region = REGION_START;
         end else if (c2 <= c1) begin
            nx = ex; ny = ey; r.region = REGION_END;
         end else begin
            nx = sx + foot_offset(c1, vx, c2);
            ny = sy + foot_offset(c1, vy, c2);
            r.region = REGION_FOOT;
         end
         dx = px - nx;
         dy = py - ny;
         r.distance  = RW'(floor_sqrt(dx * dx + dy * dy));
         r.nearest_x = CW'(nx);
         r.nearest_y = CW'(ny);
         return r;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      region_hits = '{0, 0, 0};
   end

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.distance != want.distance)
                  report_mismatch("distance", rsp_data.distance, want.distance);
               if (rsp_data.nearest_x != want.nearest_x)
                  report_mismatch("nearest_x", rsp_data.nearest_x, want.nearest_x);
               if (rsp_data.nearest_y != want.nearest_y)
                  report_mismatch("nearest_y", rsp_data.nearest_y, want.nearest_y);
               if (rsp_data.region != want.region)
                  report_mismatch("region", rsp_data.region, want.region);
               if (want.region <= REGION_FOOT) region_hits[want.region]++;
            end
         end
         if (req_valid && req_ready)
            expected_rsps = {expected_rsps, nearest_on_segment(req_data)};
      end
   end
endmodule

### sim/point_segment_nearest_core_tb.sv
// testbench top for the point to segment nearest point core: directed and
// random request stimulus with random stalls; checking is in the checker
// depends on psn_pkg, point_segment_nearest_core and point_segment_nearest_checker
module point_segment_nearest_core_tb import psn_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1210;
   localparam int DRAIN_CYCLES = 80;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      region_hits [3];
   int      sent_count;
   bit      stall_free;
   bit      long_hold;

   point_segment_nearest_core i_dut (.*);

   point_segment_nearest_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("point_segment_nearest_core_tb NOT OK");
      $finish;
   end

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      begin
         case (mode)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 200)) - CW'(100);
            2: return ($urandom_range(0, 1)) ? CMAX - CW'($urandom_range(0, 3))
                                             : CMIN + CW'($urandom_range(0, 3));
            default: return CW'($urandom_range(0, 1 << 16)) - CW'(1 << 15);
         endcase
      end
   endfunction

   task automatic send_req(req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (!stall_free && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_coords(logic signed [CW-1:0] px, py, sx, sy, ex, ey);
      req_type q;
      q = '{px, py, sx, sy, ex, ey};
      send_req(q);
   endtask

   function automatic req_type rand_req();
      req_type q;
      int mode;
      begin
         mode = $urandom_range(0, 3);
         q.point_x = rand_coord(mode);
         q.point_y = rand_coord(mode);
         q.start_x = rand_coord(mode);
         q.start_y = rand_coord(mode);
         q.end_x   = rand_coord(mode);
         q.end_y   = rand_coord(mode);
         case ($urandom_range(0, 9))
            0: begin q.end_x = q.start_x; q.end_y = q.start_y; end
            1: begin q.point_x = q.end_x; q.point_y = q.end_y; end
            default: ;
         endcase
         return q;
      end
   endfunction

   // receiver side stalls
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) rsp_ready <= 1'b0;
         else if (stall_free) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sent_count = 0;
      stall_free = 1'b0;
      long_hold = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_coords(0, 0, 0, 0, 0, 0);
      send_coords(5, 5, 3, 3, 3, 3);
      send_coords(10, 0, 0, 0, 10, 0);
      send_coords(20, 7, 0, 0, 10, 0);
      send_coords(-5, 3, 0, 0, 10, 0);
      send_coords(5, 5, 0, 0, 10, 0);
      send_coords(1, 0, 0, 0, 2, 1);
      send_coords(1, 2, 0, 0, 3, 3);
      send_coords(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
      send_coords(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
      send_coords(CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
      send_coords(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
      send_coords(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
      send_coords(0, CMAX, CMIN, 0, CMAX, 0);
      send_coords(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
      send_coords(-1, -1, 0, 0, -3, -1);
      send_coords(2, -1, 0, 0, 4, -2);

      // receiver holds off while the sender keeps offering
      long_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         repeat (120) send_req(rand_req());
      join

      // sender pauses until everything has drained
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         stall_free = (i >= 500 && i < 700);
         send_req(rand_req());
      end
      stall_free = 1'b0;
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests: start %0d, end %0d, foot %0d responses",
               sent_count, region_hits[0], region_hits[1], region_hits[2]);
      if (error_count == 0) begin
         $display("point_segment_nearest_core_tb OK");
      end else begin
         $display("point_segment_nearest_core_tb NOT OK");
      end
      $finish;
   end
endmodule
